FILE: sv/hskg_pkg.sv
// ----------------------------------------------------------------------------
// hskg_pkg
// Shared types, constants and helper functions for the hashed seed key
// generator: FNV-1a and LCG constants, item structs, case fold, symbol map.
// ----------------------------------------------------------------------------
`default_nettype none

package hskg_pkg;

  // FNV-1a 32-bit constants
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // linear congruential generator constants
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_INC = 32'd1013904223;

  // mask character that asks for a generated symbol
  localparam logic [15:0] STAR_CODE = 16'h002A;

  // action codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_MASK   = 1'b1;

  // symbol alphabet: A-Z then 0-9
  localparam int unsigned SYMBOL_COUNT = 36;
  localparam int unsigned LETTER_COUNT = 26;

  // one input item
  typedef struct packed {
    logic        action;
    logic [15:0] char_code;
    logic        first;
    logic        last;
  } in_item_t;

  // mask item after the generator step
  typedef struct packed {
    logic [15:0] sel_hi;     // upper half of the new generator state
    logic [15:0] char_code;
    logic        star;
    logic        last;
  } mid_item_t;

  // one result item
  typedef struct packed {
    logic [15:0] key_char;
    logic        key_last;
  } out_item_t;

  // state visible to the top level
  typedef struct packed {
    logic [31:0] name_hash;
    logic [31:0] gen_state;
  } state_stat_t;

  // fold ASCII a-z to upper case, everything else unchanged
  function automatic logic [15:0] fold_upper(input logic [15:0] c);
    logic [15:0] res;
    res = c;
    if (c >= 16'h0061 && c <= 16'h007A) begin
      res = c - 16'h0020;
    end
    return res;
  endfunction

  // symbol for an index below SYMBOL_COUNT
  function automatic logic [15:0] symbol_of(input logic [5:0] idx);
    logic [15:0] res;
    if (idx < 6'(LETTER_COUNT)) begin
      res = 16'h0041 + 16'(idx);
    end else begin
      res = 16'h0030 + 16'(idx - 6'(LETTER_COUNT));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hskg_if.sv
// ----------------------------------------------------------------------------
// hskg interfaces
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hskg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] char_code;
  logic        first;
  logic        last;

  modport source (output valid, output action, output char_code,
                  output first, output last, input ready);
  modport sink   (input valid, input action, input char_code,
                  input first, input last, output ready);
endinterface

interface hskg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_char;
  logic        key_last;

  modport source (output valid, output key_char, output key_last, input ready);
  modport sink   (input valid, input key_char, input key_last, output ready);
endinterface

`default_nettype wire

FILE: sv/hskg_update.sv
// ----------------------------------------------------------------------------
// hskg_update
// Holds the name hash and the generator state. Absorbs a name item into the
// FNV-1a hash, or seeds (first) and steps (on '*') the LCG for a mask item.
// ----------------------------------------------------------------------------
`default_nettype none

module hskg_update (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,        // item leaves the input register
  input  hskg_pkg::in_item_t   item,
  output hskg_pkg::mid_item_t  mid,
  output hskg_pkg::state_stat_t stat
);

  logic [31:0] name_hash_r, name_hash_nxt;
  logic [31:0] gen_state_r, gen_state_nxt;
  logic [31:0] hash_base;
  logic [31:0] seed;
  logic [31:0] lcg_step;
  logic        is_star;

  // FNV-1a absorb
  always_comb begin
    hash_base = item.first ? hskg_pkg::FNV_BASIS : name_hash_r;
  end

  // LCG seed and step
  always_comb begin
    seed     = item.first ? name_hash_r : gen_state_r;
    lcg_step = seed * hskg_pkg::LCG_MUL + hskg_pkg::LCG_INC;
    is_star  = (item.char_code == hskg_pkg::STAR_CODE);
  end

  // next state
  always_comb begin
    name_hash_nxt = name_hash_r;
    gen_state_nxt = gen_state_r;
    if (go) begin
      if (item.action == hskg_pkg::ACT_ABSORB) begin
        name_hash_nxt = (hash_base ^ {16'b0, hskg_pkg::fold_upper(item.char_code)})
                        * hskg_pkg::FNV_PRIME;
      end else begin
        gen_state_nxt = is_star ? lcg_step : seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_hash_r <= hskg_pkg::FNV_BASIS;
      gen_state_r <= '0;
    end else begin
      name_hash_r <= name_hash_nxt;
      gen_state_r <= gen_state_nxt;
    end
  end

  // mask item for the symbol stage
  always_comb begin
    mid.sel_hi    = lcg_step[31:16];
    mid.char_code = item.char_code;
    mid.star      = is_star;
    mid.last      = item.last;
  end

  assign stat.name_hash = name_hash_r;
  assign stat.gen_state = gen_state_r;

endmodule

`default_nettype wire

FILE: sv/hskg_symbol.sv
// ----------------------------------------------------------------------------
// hskg_symbol
// Maps the upper generator half modulo 36 onto A-Z0-9, or passes the mask
// character through. x mod 36 = 4 * ((x >> 2) mod 9) + (x & 3).
// ----------------------------------------------------------------------------
`default_nettype none

module hskg_symbol (
  input  hskg_pkg::mid_item_t mid,
  output hskg_pkg::out_item_t res
);

  logic [13:0] quarter;
  logic [26:0] prod;
  logic [10:0] quot;
  logic [13:0] nine_q;
  logic [13:0] rem_raw;
  logic [3:0]  rem9;
  logic [5:0]  idx;

  // mod 9 by reciprocal: quotient is exact or one low, so one correction
  always_comb begin
    quarter = mid.sel_hi[15:2];
    prod    = 27'(quarter) * 27'd7281;
    quot    = prod[26:16];
    nine_q  = 14'({quot, 3'b000}) + 14'(quot);
    rem_raw = quarter - nine_q;
    if (rem_raw[4:0] >= 5'd9) begin
      rem9 = 4'(rem_raw[4:0] - 5'd9);
    end else begin
      rem9 = rem_raw[3:0];
    end
    idx = {rem9, mid.sel_hi[1:0]};
  end

  // select generated symbol or pass-through
  always_comb begin
    res.key_char = mid.star ? hskg_pkg::symbol_of(idx) : mid.char_code;
    res.key_last = mid.last;
  end

endmodule

`default_nettype wire

FILE: sv/hashed_seed_key_generator.sv
// A mask item passes the input, mask and result registers to out_chan.
// Throughput: one item per cycle; the hash and generator update sits in one
// stage, so a name or mask item can follow in the very next cycle.
// Name items give no result. Ready is held back only by a stalled output.
// Reset (synchronous, active low) empties all stages, loads the FNV offset
// basis into the hash and clears the generator state.
// ----------------------------------------------------------------------------
// hashed_seed_key_generator
// Seeded key generator: FNV-1a name hash, LCG step per '*', A-Z0-9 output.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_seed_key_generator (
  input  logic    clk,
  input  logic    rst_n,
  hskg_in_if.sink in_chan,
  hskg_out_if.source out_chan
);

  // pipeline registers
  logic                  s1_v_r, s1_v_nxt;
  hskg_pkg::in_item_t    s1_r, s1_nxt;
  logic                  s2_v_r, s2_v_nxt;
  hskg_pkg::mid_item_t   s2_r, s2_nxt;
  logic                  s3_v_r, s3_v_nxt;
  hskg_pkg::out_item_t   s3_r, s3_nxt;

  hskg_pkg::in_item_t    in_item;
  hskg_pkg::mid_item_t   mid_item;
  hskg_pkg::out_item_t   sym_item;
  hskg_pkg::state_stat_t stat;

  logic in_acc;
  logic s1_go;
  logic s2_load_ok;
  logic s3_load_ok;

  // flow control
  always_comb begin
    s3_load_ok = !s3_v_r || out_chan.ready;
    s2_load_ok = !s2_v_r || s3_load_ok;
    s1_go      = s1_v_r && s2_load_ok;
    in_acc     = in_chan.valid && in_chan.ready;
  end

  assign in_chan.ready = !s1_v_r || s1_go;

  always_comb begin
    in_item.action    = in_chan.action;
    in_item.char_code = in_chan.char_code;
    in_item.first     = in_chan.first;
    in_item.last      = in_chan.last;
  end

  // state update and generator step
  hskg_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_r),
    .mid   (mid_item),
    .stat  (stat)
  );

  // modulo and symbol lookup
  hskg_symbol u_symbol (
    .mid (s2_r),
    .res (sym_item)
  );

  // next values of the stages
  always_comb begin
    s1_v_nxt = s1_v_r;
    s1_nxt   = s1_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
      s1_nxt   = in_item;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end

    s2_v_nxt = s2_v_r;
    s2_nxt   = s2_r;
    if (s2_load_ok) begin
      s2_v_nxt = s1_go && (s1_r.action == hskg_pkg::ACT_MASK);
      s2_nxt   = mid_item;
    end

    s3_v_nxt = s3_v_r;
    s3_nxt   = s3_r;
    if (s3_load_ok) begin
      s3_v_nxt = s2_v_r;
      s3_nxt   = sym_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  assign out_chan.valid    = s3_v_r;
  assign out_chan.key_char = s3_r.key_char;
  assign out_chan.key_last = s3_r.key_last;

  // a name item never reaches the symbol stage
  a_absorb_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.action == hskg_pkg::ACT_ABSORB) |=> !s2_v_r)
    else $error("name item produced a mask stage entry");

  // the hash moves only when a name item leaves the input register
  a_hash_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && s1_r.action == hskg_pkg::ACT_ABSORB) |=> $stable(stat.name_hash))
    else $error("name hash changed without a name item");

  // the generator moves only when a mask item leaves the input register
  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && s1_r.action == hskg_pkg::ACT_MASK) |=> $stable(stat.gen_state))
    else $error("generator state changed without a mask item");

  // an empty input register always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_chan.ready)
    else $error("input not ready with empty input register");

endmodule

`default_nettype wire

FILE: tb/hashed_seed_key_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_seed_key_generator_tb
// Drives name and mask characters through the key generator and checks every
// key character against a cycle-free model of the FNV-1a name hash and the
// seeded LCG, over phases with no idling, sender gaps, receiver stalls and both.
// ----------------------------------------------------------------------------

module hashed_seed_key_generator_tb;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;

  logic clk;
  logic rst_n;

  hskg_in_if  in_chan ();
  hskg_out_if out_chan ();

  hashed_seed_key_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // characters waiting to be sent, key characters waiting to arrive
  hskg_pkg::in_item_t  char_queue[$];
  hskg_pkg::out_item_t expected_keys[$];
  hskg_pkg::in_item_t  cur_char;

  // model state
  logic [31:0] name_digest;
  logic [31:0] lcg_word;

  int send_idle_pct;
  int recv_stall_pct;
  int calm_left;
  int quiet_cycles;
  int fail_count;
  int phase_items;

  always #6 clk = ~clk;

  // fold ASCII a-z only
  function automatic logic [15:0] upcase(input logic [15:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) begin
      return c - 16'h0020;
    end
    return c;
  endfunction

  // update the model with one accepted character, queue its key character
  task automatic predict_key_char(input hskg_pkg::in_item_t it);
    logic [15:0]         idx;
    hskg_pkg::out_item_t k;
    if (it.action == hskg_pkg::ACT_ABSORB) begin
      if (it.first) begin
        name_digest = hskg_pkg::FNV_BASIS;
      end
      name_digest = (name_digest ^ {16'h0000, upcase(it.char_code)})
                    * hskg_pkg::FNV_PRIME;
    end else begin
      if (it.first) begin
        lcg_word = name_digest;
      end
      if (it.char_code == hskg_pkg::STAR_CODE) begin
        lcg_word = lcg_word * hskg_pkg::LCG_MUL + hskg_pkg::LCG_INC;
        idx = 16'(lcg_word[31:16] % 16'd36);
        if (idx < 16'd26) begin
          k.key_char = 16'h0041 + idx;
        end else begin
          k.key_char = 16'h0030 + (idx - 16'd26);
        end
      end else begin
        k.key_char = it.char_code;
      end
      k.key_last = it.last;
      expected_keys.push_back(k);
    end
  endtask

  task automatic push_char(input logic act, input logic [15:0] code,
                           input logic fst, input logic lst);
    hskg_pkg::in_item_t it;
    it.action    = act;
    it.char_code = code;
    it.first     = fst;
    it.last      = lst;
    char_queue.push_back(it);
    phase_items++;
  endtask

  function automatic logic [15:0] name_code();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h61, 16'h7A));
      1:       return 16'($urandom_range(16'h41, 16'h5A));
      2:       return 16'($urandom_range(16'h20, 16'h7E));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] mask_code();
    case ($urandom_range(0, 9))
      0:       return 16'h002D;
      1:       return 16'($urandom_range(16'h20, 16'h7E));
      2:       return 16'($urandom_range(0, 16'hFFFF));
      default: return hskg_pkg::STAR_CODE;
    endcase
  endfunction

  // a name, the hash restarted on its first character when asked
  task automatic gen_name(input int n, input bit restart);
    for (int i = 0; i < n; i++) begin
      push_char(hskg_pkg::ACT_ABSORB, name_code(), restart && i == 0,
                ($urandom_range(0, 7) == 0));
    end
  endtask

  // a mask, seeded on its first character and closed on its last when asked
  task automatic gen_mask(input int n, input bit seed, input bit finish);
    for (int i = 0; i < n; i++) begin
      push_char(hskg_pkg::ACT_MASK, mask_code(), seed && i == 0, finish && i == n - 1);
    end
  endtask

  // runs of cycles with no idling on either side
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      calm_left <= $urandom_range(10, 40);
    end
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_key_char(cur_char);
      end
      if (in_chan.valid && !in_chan.ready) begin
        // hold the item until it is taken
      end else if (char_queue.size() > 0 &&
                   (calm_left > 0 || $urandom_range(0, 99) >= send_idle_pct)) begin
        cur_char = char_queue.pop_front();
        in_chan.valid     <= 1'b1;
        in_chan.action    <= cur_char.action;
        in_chan.char_code <= cur_char.char_code;
        in_chan.first     <= cur_char.first;
        in_chan.last      <= cur_char.last;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    hskg_pkg::out_item_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      quiet_cycles   <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_keys.size() == 0) begin
          $error("unexpected key item: key_char %h key_last %b",
                 out_chan.key_char, out_chan.key_last);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          if (out_chan.key_char !== want.key_char) begin
            $error("key_char: expected %h, got %h", want.key_char, out_chan.key_char);
            fail_count++;
          end
          if (out_chan.key_last !== want.key_last) begin
            $error("key_last: expected %b, got %b", want.key_last, out_chan.key_last);
            fail_count++;
          end
        end
      end
      out_chan.ready <= (calm_left > 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[hashed_seed_key_generator] ERROR");
    $finish;
  end

  // stimulus and phases
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.action    = hskg_pkg::ACT_ABSORB;
    in_chan.char_code = 16'h0000;
    in_chan.first     = 1'b0;
    in_chan.last      = 1'b0;
    out_chan.ready    = 1'b0;
    name_digest       = hskg_pkg::FNV_BASIS;
    lcg_word          = 32'h0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    calm_left         = 0;
    quiet_cycles      = 0;
    fail_count        = 0;
    phase_items       = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_items = 0;

      if (phase == 0) begin
        // mask before any seeding runs from a zero generator
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, 16'h0041, 1'b0, 1'b0);
        // seeding with no name seen: seed is the offset basis
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b1, 1'b0);
        push_char(hskg_pkg::ACT_MASK, 16'hFFFF, 1'b0, 1'b1);
        // name with fold edges; last on a name character is ignored
        push_char(hskg_pkg::ACT_ABSORB, 16'h0061, 1'b1, 1'b1);
        push_char(hskg_pkg::ACT_ABSORB, 16'h007A, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'h0060, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'h007B, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'h0041, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'h0000, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'hFFFF, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_ABSORB, 16'h00E1, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b1, 1'b0);
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, 16'h002D, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, 16'h0000, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b0, 1'b1);
        // name after mask leaves the generator alone
        push_char(hskg_pkg::ACT_ABSORB, 16'h0071, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b0, 1'b0);
        push_char(hskg_pkg::ACT_MASK, hskg_pkg::STAR_CODE, 1'b1, 1'b1);
      end

      while (phase_items < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          8: begin
            // noise
            repeat ($urandom_range(1, 5)) begin
              push_char(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
          end
          9: begin
            // broken key: flags missing or misplaced
            gen_name($urandom_range(0, 6), 1'($urandom_range(0, 1)));
            gen_mask($urandom_range(1, 10), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          end
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              gen_name(0, 1'b1);
            end else begin
              gen_name($urandom_range(1, 12), 1'b1);
            end
            gen_mask($urandom_range(1, 20), 1'b1, 1'b1);
          end
        endcase
      end

      // let the phase drain completely
      while (char_queue.size() > 0 || in_chan.valid || expected_keys.size() > 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_keys.size() == 0) begin
      $display("[hashed_seed_key_generator] OK");
    end else begin
      $display("[hashed_seed_key_generator] ERROR");
    end
    $finish;
  end

endmodule
